// ===== hw/rtl/mesi_pkg.sv =====
// Package: sizes, state codes and opcodes for the MESI cache tag controller.
`timescale 1ns / 1ps
package mesi_pkg;
    localparam int MAX_SET_BITS = 8;
    localparam int NUM_WAYS     = 4;
    localparam int ADDR_WIDTH   = 32;
    localparam int TAG_WIDTH    = ADDR_WIDTH - 3;
    localparam int WAY_BITS     = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
    localparam int SET_COUNT    = 1 << MAX_SET_BITS;

    localparam logic [1:0] ST_INV = 2'd0;
    localparam logic [1:0] ST_SHR = 2'd1;
    localparam logic [1:0] ST_EXC = 2'd2;
    localparam logic [1:0] ST_MOD = 2'd3;

    localparam logic [2:0] OP_RD   = 3'd0;
    localparam logic [2:0] OP_WR   = 3'd1;
    localparam logic [2:0] OP_SRD  = 3'd2;
    localparam logic [2:0] OP_SRDX = 3'd3;
    localparam logic [2:0] OP_SINV = 3'd4;
    localparam logic [2:0] OP_FILL = 3'd5;

    localparam logic [1:0] CFG_INDEX  = 2'd0;
    localparam logic [1:0] CFG_OFFSET = 2'd1;
    localparam logic [1:0] CFG_WAYS   = 2'd2;

    typedef struct packed {
        logic [MAX_SET_BITS-1:0] set;
        logic [TAG_WIDTH-1:0]    tag;
    } lookup_t;

    typedef struct packed {
        logic read;
        logic update;
    } dp_cmd_t;
endpackage

// ===== hw/rtl/mesi_ctrl.sv =====
// Controller: sequences the set read and the update/result cycle.
`timescale 1ns / 1ps
module mesi_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output mesi_pkg::dp_cmd_t cmd
);
    import mesi_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_UPD  = 1'b1;

    logic state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.read   = 1'b0;
        cmd.update = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.read   = 1'b1;
                    state_next = S_UPD;
                end
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg == S_UPD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end
endmodule

// ===== hw/rtl/mesi_dp.sv =====
// Datapath: tag, state and stamp stores, lookup, victim choice and result.
`timescale 1ns / 1ps
module mesi_dp (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mesi_pkg::dp_cmd_t      cmd,
    input  logic [2:0]             opcode,
    input  logic [31:0]            address,
    input  logic                   bus_free,
    input  logic [1:0]             fill_state,
    input  logic [3:0]             idx_bits,
    input  logic [3:0]             off_bits,
    input  logic [2:0]             ways,
    output logic                   strobe,
    output logic                   hit,
    output logic [1:0]             bus_request,
    output logic                   retry,
    output logic                   snoop_flush,
    output logic                   snoop_supply,
    output logic                   evicted,
    output logic                   evict_writeback
);
    import mesi_pkg::*;

    // Tag, coherence and stamp stores: one row per set, all ways side by side.
    // A set whose row was never written reads as all invalid with zero stamps.
    logic [NUM_WAYS*TAG_WIDTH-1:0] tag_mem   [SET_COUNT];
    logic [NUM_WAYS*32-1:0]        stamp_mem [SET_COUNT];
    logic [NUM_WAYS*2-1:0]         coh_mem   [SET_COUNT];
    logic [NUM_WAYS*TAG_WIDTH-1:0] tag_rd_reg;
    logic [NUM_WAYS*32-1:0]        stamp_rd_reg;
    logic [NUM_WAYS*2-1:0]         coh_rd_reg;
    logic [SET_COUNT-1:0]          row_vld_reg;
    logic [31:0]                   clock_reg;

    logic [3:0]            eff_idx, eff_off;
    logic [WAY_BITS:0]     eff_ways;
    lookup_t               lk, lk_reg;
    logic [2:0]            op_reg;
    logic                  bf_reg;
    logic [1:0]            fs_reg;
    logic [ADDR_WIDTH-1:0] sh;

    always_comb
    begin
        eff_idx = idx_bits;
        if (eff_idx < 4'd1) eff_idx = 4'd1;
        if (eff_idx > 4'(MAX_SET_BITS)) eff_idx = 4'(MAX_SET_BITS);
        eff_off = off_bits;
        if (eff_off < 4'd2) eff_off = 4'd2;
        if (eff_off > 4'd12) eff_off = 4'd12;
        eff_ways = (WAY_BITS+1)'(ways);
        if (ways == 3'd0) eff_ways = (WAY_BITS+1)'(1);
        if ({29'd0, ways} > NUM_WAYS) eff_ways = (WAY_BITS+1)'(NUM_WAYS);
        sh = address >> eff_off;
        lk.set = MAX_SET_BITS'(sh & ((ADDR_WIDTH'(1) << eff_idx) - ADDR_WIDTH'(1)));
        lk.tag = TAG_WIDTH'(sh >> eff_idx);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.read)
        begin
            tag_rd_reg   <= tag_mem[lk.set];
            stamp_rd_reg <= stamp_mem[lk.set];
            coh_rd_reg   <= coh_mem[lk.set];
            lk_reg       <= lk;
            op_reg       <= opcode;
            bf_reg       <= bus_free;
            fs_reg       <= fill_state;
        end
    end

    // Update cycle logic
    logic [1:0]          coh [NUM_WAYS];
    logic [31:0]         stp [NUM_WAYS];
    logic                match;
    logic [WAY_BITS-1:0] mway, pick;
    logic                found_inv;
    logic [1:0]          st, new_st;
    logic                wr_tag, wr_stamp, wr_coh;
    logic [WAY_BITS-1:0] wway;
    logic [31:0]         new_stamp, clock_next;
    logic                o_hit, o_retry, o_flush, o_sup, o_ev, o_wb;
    logic [1:0]          o_bus;

    always_comb
    begin
        match = 1'b0;
        mway  = '0;
        found_inv = 1'b0;
        pick = '0;
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            coh[w] = row_vld_reg[lk_reg.set] ? coh_rd_reg[w*2 +: 2] : ST_INV;
            stp[w] = row_vld_reg[lk_reg.set] ? stamp_rd_reg[w*32 +: 32] : 32'd0;
        end
        for (int w = NUM_WAYS-1; w >= 0; w--)
        begin
            if ((WAY_BITS+1)'(w) < eff_ways && coh[w] != ST_INV
                && tag_rd_reg[w*TAG_WIDTH +: TAG_WIDTH] == lk_reg.tag)
            begin
                match = 1'b1;
                mway  = WAY_BITS'(w);
            end
        end
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            if ((WAY_BITS+1)'(w) < eff_ways && !found_inv)
            begin
                if (coh[w] == ST_INV)
                begin
                    found_inv = 1'b1;
                    pick = WAY_BITS'(w);
                end
                else if (w == 0 || stp[w] < stp[pick])
                    pick = WAY_BITS'(w);
            end
        end
        st = coh[mway];
        new_st = st;
        wr_tag = 1'b0; wr_stamp = 1'b0; wr_coh = 1'b0;
        wway = mway;
        new_stamp = clock_reg + 32'd1;
        clock_next = clock_reg;
        o_hit = 1'b0; o_retry = 1'b0; o_flush = 1'b0; o_sup = 1'b0;
        o_ev = 1'b0; o_wb = 1'b0; o_bus = 2'd0;
        case (op_reg)
            OP_RD, OP_WR:
            begin
                if (!match)
                    o_bus = (op_reg == OP_WR) ? 2'd2 : 2'd1;
                else
                begin
                    wr_stamp = 1'b1;
                    clock_next = clock_reg + 32'd1;
                    if (op_reg == OP_RD)
                        o_hit = 1'b1;
                    else if (st == ST_SHR)
                    begin
                        if (bf_reg)
                        begin
                            new_st = ST_MOD; wr_coh = 1'b1; o_hit = 1'b1; o_bus = 2'd3;
                        end
                        else
                        begin
                            clock_next = clock_reg;
                            new_stamp = clock_reg;
                            o_retry = 1'b1;
                        end
                    end
                    else
                    begin
                        new_st = ST_MOD; wr_coh = 1'b1; o_hit = 1'b1;
                    end
                end
            end
            OP_SRD:
            begin
                if (match)
                begin
                    o_flush = (st == ST_MOD);
                    o_sup = (st != ST_MOD);
                    new_st = ST_SHR; wr_coh = 1'b1;
                end
            end
            OP_SRDX, OP_SINV:
            begin
                if (match)
                begin
                    o_flush = (op_reg == OP_SRDX) && (st == ST_MOD);
                    new_st = ST_INV; wr_coh = 1'b1;
                end
            end
            OP_FILL:
            begin
                wway = pick;
                o_ev = !found_inv;
                o_wb = !found_inv && coh[pick] == ST_MOD;
                new_st = (fs_reg >= 2'd2) ? ST_MOD : fs_reg + 2'd1;
                wr_tag = 1'b1; wr_coh = 1'b1; wr_stamp = 1'b1;
                clock_next = clock_reg + 32'd1;
            end
            default: ;
        endcase
    end

    logic [NUM_WAYS*32-1:0]        stamp_row;
    logic [NUM_WAYS*TAG_WIDTH-1:0] tag_row;
    logic [NUM_WAYS*2-1:0]         coh_row;
    always_comb
    begin
        for (int w = 0; w < NUM_WAYS; w++)
        begin
            stamp_row[w*32 +: 32] = stp[w];
            coh_row[w*2 +: 2] = coh[w];
        end
        stamp_row[wway*32 +: 32] = new_stamp;
        coh_row[wway*2 +: 2] = new_st;
        tag_row = tag_rd_reg;
        tag_row[wway*TAG_WIDTH +: TAG_WIDTH] = lk_reg.tag;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update && wr_stamp)
            stamp_mem[lk_reg.set] <= stamp_row;
        if (cmd.update && wr_tag)
            tag_mem[lk_reg.set] <= tag_row;
        if (cmd.update && wr_coh)
            coh_mem[lk_reg.set] <= coh_row;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
            clock_reg <= 32'd0;
            strobe <= 1'b0;
        end
        else
        begin
            strobe <= cmd.update;
            if (cmd.update)
            begin
                clock_reg <= clock_next;
                if (wr_coh || wr_stamp)
                    row_vld_reg[lk_reg.set] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            hit <= o_hit; bus_request <= o_bus; retry <= o_retry;
            snoop_flush <= o_flush; snoop_supply <= o_sup;
            evicted <= o_ev; evict_writeback <= o_wb;
        end
    end
endmodule

// ===== hw/rtl/mesi_snooping_cache_controller.sv =====
// Top level: MESI snooping cache tag controller with configuration registers.
// Start reads the set into registers, the update state writes it back and
// registers the result with done; busy is high in the update state only.
// Results cannot be stalled. Reset (rst_n, async) invalidates all lines,
// clears stamps and the use clock, and loads index 6, offset 5, ways 4.
`timescale 1ns / 1ps
module mesi_snooping_cache_controller (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [31:0] address,
    input  logic        bus_free,
    input  logic [1:0]  fill_state,
    output logic        done,
    output logic        hit,
    output logic [1:0]  bus_request,
    output logic        retry,
    output logic        snoop_flush,
    output logic        snoop_supply,
    output logic        evicted,
    output logic        evict_writeback,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [3:0]  cfg_data
);
    import mesi_pkg::*;

    dp_cmd_t    cmd;
    logic [3:0] idx_reg, off_reg;
    logic [2:0] ways_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= 4'd6;
            off_reg  <= 4'd5;
            ways_reg <= 3'd4;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INDEX:  idx_reg  <= cfg_data;
                CFG_OFFSET: off_reg  <= cfg_data;
                CFG_WAYS:   ways_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    mesi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    mesi_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .opcode          (opcode),
        .address         (address),
        .bus_free        (bus_free),
        .fill_state      (fill_state),
        .idx_bits        (idx_reg),
        .off_bits        (off_reg),
        .ways            (ways_reg),
        .strobe          (done),
        .hit             (hit),
        .bus_request     (bus_request),
        .retry           (retry),
        .snoop_flush     (snoop_flush),
        .snoop_supply    (snoop_supply),
        .evicted         (evicted),
        .evict_writeback (evict_writeback)
    );
endmodule

// ===== bench/testbench.sv =====
// Testbench for the MESI snooping cache tag controller: directed table plus random traffic.
`timescale 1ns / 1ps
module testbench;
    import mesi_pkg::*;

    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;
    localparam logic [1:0] BR_NONE   = 2'd0;
    localparam logic [1:0] BR_READ   = 2'd1;
    localparam logic [1:0] BR_RDX    = 2'd2;
    localparam logic [1:0] BR_INV    = 2'd3;
    localparam logic [1:0] FS_SHR    = 2'd0;
    localparam logic [1:0] FS_EXC    = 2'd1;
    localparam logic [1:0] FS_MOD    = 2'd2;
    localparam logic [1:0] FS_MOD3   = 2'd3;
    localparam int LINES = SET_COUNT * NUM_WAYS;

    typedef struct packed {
        logic       hit;
        logic [1:0] bus_req;
        logic       retry;
        logic       flush;
        logic       supply;
        logic       evicted;
        logic       writeback;
    } outcome_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] addr;
        logic        bfree;
        logic [1:0]  fstate;
        logic        typed;
        outcome_t    want;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [2:0]  opcode = '0;
    logic [31:0] address = '0;
    logic        bus_free = 1'b0;
    logic [1:0]  fill_state = '0;
    logic        done;
    logic        hit;
    logic [1:0]  bus_request;
    logic        retry;
    logic        snoop_flush;
    logic        snoop_supply;
    logic        evicted;
    logic        evict_writeback;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [3:0]  cfg_data = '0;

    logic [TAG_WIDTH-1:0] mdl_tag [LINES];
    logic [1:0]           mdl_coh [LINES];
    logic [31:0]          mdl_stamp [LINES];
    logic [31:0]          mdl_clock;
    logic [3:0]           mdl_index_bits;
    logic [3:0]           mdl_offset_bits;
    logic [2:0]           mdl_ways;

    outcome_t expected_q[$];
    int err_count = 0;
    int beats_seen = 0;
    int hits_seen = 0;
    int evicts_seen = 0;
    logic [31:0] addr_pool[16];

    mesi_snooping_cache_controller u_dut (.*);

    always #6 clk = ~clk;

    function automatic outcome_t cache_step(logic [2:0] op, logic [31:0] addr,
                                            logic bfree, logic [1:0] fs);
        outcome_t r;
        int ib, ob, nw, set, base, m, pick;
        logic [TAG_WIDTH-1:0] tg;
        logic [1:0] st;
        bit found_inv;
        r = '0;
        if (op > OP_FILL) return r;
        ib = (mdl_index_bits < 1) ? 1 : (mdl_index_bits > MAX_SET_BITS) ? MAX_SET_BITS
             : mdl_index_bits;
        ob = (mdl_offset_bits < 2) ? 2 : (mdl_offset_bits > 12) ? 12 : mdl_offset_bits;
        nw = (mdl_ways < 1) ? 1 : (mdl_ways > NUM_WAYS) ? NUM_WAYS : mdl_ways;
        set = (addr >> ob) & ((1 << ib) - 1);
        tg = TAG_WIDTH'(addr >> (ib + ob));
        base = set * NUM_WAYS;
        m = -1;
        for (int w = 0; w < nw; w++)
            if (m < 0 && mdl_coh[base + w] != ST_INV && mdl_tag[base + w] == tg) m = base + w;
        if (op == OP_RD || op == OP_WR) begin
            if (m < 0) begin
                r.bus_req = (op == OP_WR) ? BR_RDX : BR_READ;
            end else begin
                mdl_clock++;
                mdl_stamp[m] = mdl_clock;
                if (op == OP_RD) begin
                    r.hit = 1'b1;
                end else if (mdl_coh[m] == ST_SHR) begin
                    if (bfree) begin
                        mdl_coh[m] = ST_MOD;
                        r.hit = 1'b1;
                        r.bus_req = BR_INV;
                    end else begin
                        mdl_clock--;
                        mdl_stamp[m] = mdl_clock;
                        r.retry = 1'b1;
                    end
                end else begin
                    mdl_coh[m] = ST_MOD;
                    r.hit = 1'b1;
                end
            end
        end else if (op != OP_FILL) begin
            if (m >= 0) begin
                st = mdl_coh[m];
                if (op == OP_SRD) begin
                    if (st == ST_MOD) r.flush = 1'b1;
                    else r.supply = 1'b1;
                    mdl_coh[m] = ST_SHR;
                end else begin
                    if (op == OP_SRDX && st == ST_MOD) r.flush = 1'b1;
                    mdl_coh[m] = ST_INV;
                end
            end
        end else begin
            pick = base;
            found_inv = 0;
            for (int w = 0; w < nw; w++) begin
                if (!found_inv) begin
                    if (mdl_coh[base + w] == ST_INV) begin
                        pick = base + w;
                        found_inv = 1;
                    end else if (w == 0 || mdl_stamp[base + w] < mdl_stamp[pick]) begin
                        pick = base + w;
                    end
                end
            end
            if (!found_inv) begin
                r.evicted = 1'b1;
                r.writeback = (mdl_coh[pick] == ST_MOD);
            end
            mdl_tag[pick] = tg;
            mdl_coh[pick] = (fs >= FS_MOD) ? ST_MOD : fs + 2'd1;
            mdl_clock++;
            mdl_stamp[pick] = mdl_clock;
        end
        return r;
    endfunction

    always @(posedge clk) begin
        if (rst_n && done) begin
            outcome_t got, want;
            got = '{hit, bus_request, retry, snoop_flush, snoop_supply, evicted,
                    evict_writeback};
            beats_seen++;
            if (hit) hits_seen++;
            if (evicted) evicts_seen++;
            if (expected_q.size() == 0) begin
                $error("result beat with nothing expected");
                err_count++;
            end else begin
                want = expected_q.pop_front();
                if (got.hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, got.hit);
                    err_count++;
                end
                if (got.bus_req !== want.bus_req) begin
                    $error("bus_request: expected %0d, got %0d", want.bus_req, got.bus_req);
                    err_count++;
                end
                if (got.retry !== want.retry) begin
                    $error("retry: expected %0d, got %0d", want.retry, got.retry);
                    err_count++;
                end
                if (got.flush !== want.flush) begin
                    $error("snoop_flush: expected %0d, got %0d", want.flush, got.flush);
                    err_count++;
                end
                if (got.supply !== want.supply) begin
                    $error("snoop_supply: expected %0d, got %0d", want.supply, got.supply);
                    err_count++;
                end
                if (got.evicted !== want.evicted) begin
                    $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
                    err_count++;
                end
                if (got.writeback !== want.writeback) begin
                    $error("evict_writeback: expected %0d, got %0d", want.writeback,
                           got.writeback);
                    err_count++;
                end
            end
        end
    end

    task automatic idle_gap();
        int g, pick;
        pick = $urandom_range(0, 99);
        g = (pick < 55) ? 0 : (pick < 90) ? $urandom_range(1, 3) : $urandom_range(5, 20);
        if (g > 0) begin
            start <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic send_item(logic [2:0] op, logic [31:0] addr, logic bfree,
                             logic [1:0] fs, logic typed, outcome_t want);
        outcome_t p;
        start <= 1'b1;
        opcode <= op;
        address <= addr;
        bus_free <= bfree;
        fill_state <= fs;
        do @(posedge clk); while (busy);
        p = cache_step(op, addr, bfree, fs);
        expected_q.push_back(typed ? want : p);
        idle_gap();
    endtask

    task automatic drain();
        start <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_INDEX) mdl_index_bits = val;
        else if (idx == CFG_OFFSET) mdl_offset_bits = val;
        else if (idx == CFG_WAYS) mdl_ways = val[2:0];
        repeat ($urandom_range(0, 2)) @(posedge clk);
    endtask

    initial begin
        dir_row_t rows[$];
        logic [3:0] idx_set[8];
        logic [3:0] off_set[8];
        logic [2:0] way_set[8];
        logic [2:0] op;
        logic [31:0] a;
        int r;
        for (int i = 0; i < LINES; i++) begin
            mdl_tag[i] = '0;
            mdl_coh[i] = ST_INV;
            mdl_stamp[i] = '0;
        end
        mdl_clock = '0;
        mdl_index_bits = 4'd6;
        mdl_offset_bits = 4'd5;
        mdl_ways = 3'd4;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        rows.push_back('{OP_RD,   32'h0000_0000, 1'b1, FS_SHR, 1'b1, '{0, BR_READ, 0,0,0,0,0}});
        rows.push_back('{OP_WR,   32'hFFFF_FFFF, 1'b0, FS_MOD3, 1'b1, '{0, BR_RDX, 0,0,0,0,0}});
        rows.push_back('{OP_SRD,  32'h0000_0000, 1'b1, FS_SHR, 1'b1, '0});
        rows.push_back('{OP_SPARE6, 32'h0000_0000, 1'b0, FS_SHR, 1'b1, '0});
        rows.push_back('{OP_SPARE7, 32'hFFFF_FFFF, 1'b1, FS_MOD3, 1'b1, '0});
        rows.push_back('{OP_FILL, 32'h0000_0000, 1'b0, FS_EXC, 1'b1, '0});
        rows.push_back('{OP_RD,   32'h0000_001F, 1'b0, FS_SHR, 1'b1, '{1, BR_NONE, 0,0,0,0,0}});
        rows.push_back('{OP_WR,   32'h0000_0000, 1'b0, FS_SHR, 1'b1, '{1, BR_NONE, 0,0,0,0,0}});
        rows.push_back('{OP_SRD,  32'h0000_0000, 1'b0, FS_SHR, 1'b1, '{0, BR_NONE, 0,1,0,0,0}});
        rows.push_back('{OP_WR,   32'h0000_0000, 1'b0, FS_SHR, 1'b1, '{0, BR_NONE, 1,0,0,0,0}});
        rows.push_back('{OP_WR,   32'h0000_0000, 1'b1, FS_SHR, 1'b1, '{1, BR_INV, 0,0,0,0,0}});
        rows.push_back('{OP_SRDX, 32'h0000_0000, 1'b0, FS_SHR, 1'b1, '{0, BR_NONE, 0,1,0,0,0}});
        rows.push_back('{OP_FILL, 32'h0000_0000, 1'b0, FS_SHR, 1'b0, '0});
        rows.push_back('{OP_SRD,  32'h0000_0000, 1'b0, FS_SHR, 1'b1, '{0, BR_NONE, 0,0,1,0,0}});
        rows.push_back('{OP_SRDX, 32'h0000_0000, 1'b0, FS_SHR, 1'b0, '0});
        rows.push_back('{OP_FILL, 32'h0000_0800, 1'b0, FS_MOD3, 1'b0, '0});
        rows.push_back('{OP_FILL, 32'h0000_1000, 1'b0, FS_EXC, 1'b0, '0});
        rows.push_back('{OP_FILL, 32'h0000_1800, 1'b0, FS_SHR, 1'b0, '0});
        rows.push_back('{OP_FILL, 32'h0000_2000, 1'b0, FS_MOD, 1'b0, '0});
        rows.push_back('{OP_FILL, 32'h0000_2800, 1'b0, FS_EXC, 1'b1, '{0, BR_NONE, 0,0,0,1,1}});
        rows.push_back('{OP_FILL, 32'h0000_3000, 1'b0, FS_EXC, 1'b0, '0});
        rows.push_back('{OP_SINV, 32'h0000_1800, 1'b0, FS_SHR, 1'b0, '0});
        rows.push_back('{OP_SINV, 32'h0000_1000, 1'b0, FS_SHR, 1'b0, '0});
        foreach (rows[i])
            send_item(rows[i].op, rows[i].addr, rows[i].bfree, rows[i].fstate,
                      rows[i].typed, rows[i].want);
        drain();

        idx_set = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd2, 4'd6, 4'd4};
        off_set = '{4'd2, 4'd12, 4'd0, 4'd15, 4'd7, 4'd3, 4'd5, 4'd9};
        way_set = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4, 3'd2};
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CFG_INDEX, idx_set[ph]);
            write_reg(CFG_OFFSET, off_set[ph]);
            write_reg(CFG_WAYS, way_set[ph]);
            foreach (addr_pool[k]) addr_pool[k] = $urandom();
            for (int n = 0; n < 150; n++) begin
                r = $urandom_range(0, 99);
                op = (r < 28) ? OP_FILL : (r < 48) ? OP_RD : (r < 70) ? OP_WR :
                     (r < 80) ? OP_SRD : (r < 88) ? OP_SRDX : (r < 96) ? OP_SINV :
                     (r < 98) ? OP_SPARE6 : OP_SPARE7;
                a = addr_pool[$urandom_range(0, 15)];
                if ($urandom_range(0, 9) == 0) a = $urandom();
                else a = a ^ ($urandom() & 32'h0000_0FFF & ((32'd1 << off_set[ph]) - 1));
                send_item(op, a, $urandom_range(0, 1), $urandom_range(0, 3), 1'b0, '0);
            end
            drain();
        end

        $display("tb: %0d result beats checked over 9 register settings, incl. extremes",
                 beats_seen);
        $display("tb: %0d hits and %0d evictions observed", hits_seen, evicts_seen);
        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #12_000_000;
        $display("tb: failure");
        $finish;
    end
endmodule
